// ===== hw/rtl/pktref_pkg.sv =====
// ----------------------------------------------------------------------------
// pktref_pkg
// shared types, codes and helpers for the pkt-line ref advertisement parser
// ----------------------------------------------------------------------------
package pktref_pkg;

  localparam int unsigned OidHexDigitsDefault = 40;
  localparam int unsigned HeaderDigitsDefault = 4;

  localparam int unsigned EventW = 3;
  localparam int unsigned ValueW = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned ErrW   = 3;
  localparam int unsigned LenW   = 16;

  // output event kinds
  localparam logic [EventW-1:0] EvOidByte  = 3'd0;
  localparam logic [EventW-1:0] EvNameByte = 3'd1;
  localparam logic [EventW-1:0] EvCapByte  = 3'd2;
  localparam logic [EventW-1:0] EvRefEnd   = 3'd3;
  localparam logic [EventW-1:0] EvFlush    = 3'd4;
  localparam logic [EventW-1:0] EvError    = 3'd5;

  // error codes
  localparam logic [ErrW-1:0] ErrNone     = 3'd0;
  localparam logic [ErrW-1:0] ErrLenDigit = 3'd1;
  localparam logic [ErrW-1:0] ErrLenShort = 3'd2;
  localparam logic [ErrW-1:0] ErrOidDigit = 3'd3;
  localparam logic [ErrW-1:0] ErrNoSpace  = 3'd4;
  localparam logic [ErrW-1:0] ErrTooShort = 3'd5;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChNul     = 8'h00;

  typedef struct packed {
    logic [EventW-1:0] event_res;
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   position;
    logic [ErrW-1:0]   error_code;
    logic              last;
  } result_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/pkt_line_ref_advert_parser.sv =====
// ----------------------------------------------------------------------------
// pkt_line_ref_advert_parser
// deframes a pkt-line byte stream into oid, name, capability, ref end,
// flush and error events
// ----------------------------------------------------------------------------
//  channel   dir  tdata                              tuser       tlast
//  s_axis    in   data_byte[7:0]                     -           -
//  m_axis    out  value[7:0] position[23:8]          event_res   last
//                 error_code[26:24]
//
//  one byte per cycle while the queue accepts input; a byte yielding two
//  events (final payload byte plus ref end) pushes both into the queue
//  rate is set by the three-entry output queue: input ready while at most
//  one result is queued
//  results are registered in the queue before they reach m_axis
//  reset returns the parser to header reading and empties the queue
//  a stalled master side fills the queue and then holds s_axis_tready low
// ----------------------------------------------------------------------------
module pkt_line_ref_advert_parser
  import pktref_pkg::*;
#(
  parameter int unsigned OID_HEX_DIGITS = OidHexDigitsDefault,
  parameter int unsigned HEADER_DIGITS  = HeaderDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value[7:0], position[23:8], error_code[26:24]
  output logic [2:0]  m_axis_tuser,   // event_res[2:0]
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {
    PhHeader = 2'd0,
    PhBody   = 2'd1,
    PhSkip   = 2'd2
  } phase_e;

  localparam logic [LenW-1:0] OidLen  = LenW'(OID_HEX_DIGITS);
  localparam logic [LenW-1:0] HdrLen  = LenW'(HEADER_DIGITS);
  localparam logic [1:0]      HdrDone = 2'(HEADER_DIGITS);

  phase_e          phase_q, phase_d;
  logic [1:0]      seen_q, seen_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [LenW-1:0] off_q, off_d;
  logic [3:0]      nib_q, nib_d;
  logic            sep_q, sep_d;

  result_t         res0, res1;
  logic [1:0]      n_res;

  result_t         queue_q [3];
  logic [1:0]      wr_q, rd_q, cnt_q;

  logic            in_fire, out_fire;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign s_axis_tready = (cnt_q <= 2'd1);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  // parser next state and results for the byte on the input
  always_comb begin
    logic [4:0]      hv;
    logic [LenW-1:0] acc_n;
    logic [1:0]      seen_n;
    logic [LenW-1:0] body;
    logic            final_b;
    logic [7:0]      c;
    logic            as_header;
    c         = s_axis_tdata;
    hv        = hex_decode(c);
    acc_n     = {acc_q[LenW-5:0], hv[3:0]};
    seen_n    = seen_q + 2'd1;
    body      = acc_n - HdrLen;
    final_b   = (rem_q == LenW'(1));
    as_header = (phase_q != PhBody && phase_q != PhSkip) || (rem_q == '0);
    phase_d   = phase_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    off_d     = off_q;
    nib_d     = nib_q;
    sep_d     = sep_q;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    if (as_header) begin
      phase_d = PhHeader;
      if (!hv[4]) begin
        seen_d = 2'd0;
        acc_d  = '0;
        res0   = '{EvError, 8'd0, 16'd0, ErrLenDigit, 1'b1};
        n_res  = 2'd1;
      end else if (seen_n != HdrDone) begin
        seen_d = seen_n;
        acc_d  = acc_n;
      end else begin
        seen_d = 2'd0;
        acc_d  = '0;
        if (acc_n == '0) begin
          res0  = '{EvFlush, 8'd0, 16'd0, ErrNone, 1'b1};
          n_res = 2'd1;
        end else if (acc_n == HdrLen) begin
          n_res = 2'd0;
        end else if (acc_n < HdrLen) begin
          res0  = '{EvError, 8'd0, 16'd0, ErrLenShort, 1'b1};
          n_res = 2'd1;
        end else begin
          rem_d = body;
          off_d = '0;
          nib_d = 4'd0;
          sep_d = 1'b0;
          if (body < OidLen + LenW'(1)) begin
            phase_d = PhSkip;
            res0    = '{EvError, 8'd0, 16'd0, ErrTooShort, 1'b1};
            n_res   = 2'd1;
          end else begin
            phase_d = PhBody;
          end
        end
      end
    end else if (phase_q == PhSkip) begin
      rem_d = rem_q - LenW'(1);
      if (final_b) begin
        phase_d = PhHeader;
      end
    end else begin
      rem_d = rem_q - LenW'(1);
      off_d = off_q + LenW'(1);
      if (off_q < OidLen) begin
        if (!hv[4]) begin
          phase_d = final_b ? PhHeader : PhSkip;
          res0    = '{EvError, 8'd0, 16'd0, ErrOidDigit, 1'b1};
          n_res   = 2'd1;
        end else if (!off_q[0]) begin
          nib_d = hv[3:0];
          if (off_q == OidLen - LenW'(1)) begin
            res0  = '{EvOidByte, {hv[3:0], 4'd0}, off_q >> 1, ErrNone, 1'b0};
            n_res = 2'd1;
          end
        end else begin
          res0  = '{EvOidByte, {nib_q, hv[3:0]}, off_q >> 1, ErrNone, 1'b0};
          n_res = 2'd1;
        end
      end else if (off_q == OidLen) begin
        if (c != ChSpace) begin
          phase_d = final_b ? PhHeader : PhSkip;
          res0    = '{EvError, 8'd0, 16'd0, ErrNoSpace, 1'b1};
          n_res   = 2'd1;
        end
      end else begin
        if (c == ChNul && !sep_q) begin
          sep_d = 1'b1;
        end else if (!(final_b && c == ChNewline)) begin
          res0  = '{(sep_q ? EvCapByte : EvNameByte), c,
                    off_q - OidLen - LenW'(1), ErrNone, 1'b0};
          n_res = 2'd1;
        end
      end
      if (final_b && n_res != 2'd1 || final_b && res0.event_res != EvError) begin
        phase_d = PhHeader;
        if (n_res == 2'd0) begin
          res0  = '{EvRefEnd, 8'd0, 16'd0, ErrNone, 1'b1};
          n_res = 2'd1;
        end else begin
          res1  = '{EvRefEnd, 8'd0, 16'd0, ErrNone, 1'b1};
          n_res = 2'd2;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      seen_q  <= 2'd0;
      acc_q   <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      nib_q   <= 4'd0;
      sep_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      nib_q   <= nib_d;
      sep_q   <= sep_d;
    end
  end

  // output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [1:0] push;
    if (!rst_ni) begin
      wr_q  <= 2'd0;
      rd_q  <= 2'd0;
      cnt_q <= 2'd0;
    end else begin
      push = in_fire ? n_res : 2'd0;
      unique case (push)
        2'd1:    wr_q <= ptr_inc(wr_q);
        2'd2:    wr_q <= ptr_inc(ptr_inc(wr_q));
        default: wr_q <= wr_q;
      endcase
      if (out_fire) begin
        rd_q <= ptr_inc(rd_q);
      end
      cnt_q <= cnt_q + push - {1'b0, out_fire};
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) begin
      queue_q[wr_q] <= res0;
    end
    if (in_fire && n_res == 2'd2) begin
      queue_q[ptr_inc(wr_q)] <= res1;
    end
  end

  assign m_axis_tdata = {5'd0, queue_q[rd_q].error_code, queue_q[rd_q].position,
                         queue_q[rd_q].value};
  assign m_axis_tuser = queue_q[rd_q].event_res;
  assign m_axis_tlast = queue_q[rd_q].last;

endmodule

// ===== verif/tb_pkt_line_ref_advert_parser.sv =====
// ----------------------------------------------------------------------------
// tb_pkt_line_ref_advert_parser
// streams pkt-line frames into the parser and checks every event it emits.
// a short table of hand-picked bytes covers flush, empty frames, bad and
// short lengths and the hex-digit edges. random traffic follows: mostly
// well-formed ref lines with random oid, name and capability content, mixed
// with corrupted lines, short payloads, bad headers and stray bytes. an
// in-bench parser predicts each event. both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_pkt_line_ref_advert_parser;
  import pktref_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OidDigits = OidHexDigitsDefault;
  localparam int unsigned HdrDigits = HeaderDigitsDefault;
  localparam int RandItems = 950;
  localparam int DirRows   = 24;

  localparam logic [1:0] PhHeader = 2'd0;
  localparam logic [1:0] PhBody   = 2'd1;
  localparam logic [1:0] PhSkip   = 2'd2;

  typedef struct packed {
    logic [7:0]        b;
    logic              typed;
    logic [EventW-1:0] ev;
    logic [ErrW-1:0]   err;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // parser state mirror
  logic [1:0]  ps_phase = PhHeader;
  logic [1:0]  ps_hdr_cnt = '0;
  logic [15:0] ps_len_acc = '0;
  logic [15:0] ps_left = '0;
  logic [15:0] ps_off = '0;
  logic [3:0]  ps_hi_nib = '0;
  logic        ps_nul_seen = 1'b0;

  result_t     step_events[$];
  result_t     pending_events[$];
  logic [7:0]  frame_bytes[$];
  int          bytes_sent = 0;
  int          mismatches = 0;
  bit          src_steady = 1'b0;
  bit          snk_steady = 1'b0;

  dir_row_t dir_tab [DirRows] = '{
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h30, 1'b0, EvOidByte, ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h30, 1'b1, EvFlush,   ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h30, 1'b0, EvOidByte, ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h34, 1'b0, EvOidByte, ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h30, 1'b0, EvOidByte, ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h32, 1'b1, EvError,   ErrLenShort},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h78, 1'b1, EvError,   ErrLenDigit},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h30, 1'b0, EvOidByte, ErrNone},
    '{8'h30, 1'b0, EvOidByte, ErrNone}, '{8'h36, 1'b1, EvError,   ErrTooShort},
    '{8'h00, 1'b0, EvOidByte, ErrNone}, '{8'hff, 1'b0, EvOidByte, ErrNone},
    '{8'hff, 1'b1, EvError,   ErrLenDigit}, '{8'h00, 1'b1, EvError, ErrLenDigit},
    '{8'h47, 1'b1, EvError,   ErrLenDigit}, '{8'h60, 1'b1, EvError, ErrLenDigit}
  };

  pkt_line_ref_advert_parser #(
    .OID_HEX_DIGITS(OidDigits),
    .HEADER_DIGITS (HdrDigits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] h);
    h = 4'h0;
    if (c >= "0" && c <= "9") begin
      h = 4'(c - "0");
      return 1'b1;
    end
    if (c >= "a" && c <= "f") begin
      h = 4'(c - "a" + 8'd10);
      return 1'b1;
    end
    if (c >= "A" && c <= "F") begin
      h = 4'(c - "A" + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t make_event(input logic [EventW-1:0] ev, input logic [7:0] v,
                                         input logic [15:0] p, input logic [ErrW-1:0] e,
                                         input logic is_last);
    result_t r;
    r.event_res  = ev;
    r.value      = v;
    r.position   = p;
    r.error_code = e;
    r.last       = is_last;
    return r;
  endfunction

  // advances the mirror by one byte, events land in step_events
  function automatic void parse_byte(input logic [7:0] c);
    logic [3:0]  h;
    logic        fin;
    logic [15:0] off;
    logic [15:0] len;
    step_events.delete();
    if ((ps_phase == PhBody || ps_phase == PhSkip) && ps_left == 0) ps_phase = PhHeader;
    if (ps_phase == PhSkip) begin
      ps_left = ps_left - 16'd1;
      if (ps_left == 0) ps_phase = PhHeader;
      return;
    end
    if (ps_phase == PhBody) begin
      fin = (ps_left == 16'd1);
      off = ps_off;
      ps_left = ps_left - 16'd1;
      ps_off = off + 16'd1;
      if (off < OidDigits) begin
        if (!nibble_of(c, h)) begin
          ps_phase = fin ? PhHeader : PhSkip;
          step_events.push_back(make_event(EvError, 8'h00, 16'h0, ErrOidDigit, 1'b1));
          return;
        end
        if (!off[0]) begin
          ps_hi_nib = h;
          if (off + 1 == OidDigits)
            step_events.push_back(make_event(EvOidByte, {h, 4'h0}, {1'b0, off[15:1]},
                                             ErrNone, 1'b0));
        end else begin
          step_events.push_back(make_event(EvOidByte, {ps_hi_nib, h}, {1'b0, off[15:1]},
                                           ErrNone, 1'b0));
        end
      end else if (off == OidDigits) begin
        if (c != ChSpace) begin
          ps_phase = fin ? PhHeader : PhSkip;
          step_events.push_back(make_event(EvError, 8'h00, 16'h0, ErrNoSpace, 1'b1));
          return;
        end
      end else begin
        if (c == ChNul && !ps_nul_seen) begin
          ps_nul_seen = 1'b1;
        end else if (!(fin && c == ChNewline)) begin
          step_events.push_back(make_event(ps_nul_seen ? EvCapByte : EvNameByte, c,
                                           16'(off - OidDigits - 1), ErrNone, 1'b0));
        end
      end
      if (fin) begin
        ps_phase = PhHeader;
        step_events.push_back(make_event(EvRefEnd, 8'h00, 16'h0, ErrNone, 1'b1));
      end
      return;
    end
    ps_phase = PhHeader;
    if (!nibble_of(c, h)) begin
      ps_hdr_cnt = '0;
      ps_len_acc = '0;
      step_events.push_back(make_event(EvError, 8'h00, 16'h0, ErrLenDigit, 1'b1));
      return;
    end
    ps_len_acc = {ps_len_acc[11:0], h};
    if (ps_hdr_cnt != 2'(HdrDigits - 1)) begin
      ps_hdr_cnt = ps_hdr_cnt + 2'd1;
      return;
    end
    len = ps_len_acc;
    ps_hdr_cnt = '0;
    ps_len_acc = '0;
    if (len == 0) begin
      step_events.push_back(make_event(EvFlush, 8'h00, 16'h0, ErrNone, 1'b1));
      return;
    end
    if (len == HdrDigits) return;
    if (len < HdrDigits) begin
      step_events.push_back(make_event(EvError, 8'h00, 16'h0, ErrLenShort, 1'b1));
      return;
    end
    ps_left = len - 16'(HdrDigits);
    ps_off = '0;
    ps_hi_nib = '0;
    ps_nul_seen = 1'b0;
    if (ps_left < OidDigits + 1) begin
      ps_phase = PhSkip;
      step_events.push_back(make_event(EvError, 8'h00, 16'h0, ErrTooShort, 1'b1));
      return;
    end
    ps_phase = PhBody;
  endfunction

  function automatic int pick_gap();
    int r;
    if (src_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_byte(b);
    if (typed) begin
      pending_events.push_back(want);
    end else begin
      foreach (step_events[i]) pending_events.push_back(step_events[i]);
    end
    bytes_sent++;
  endtask

  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_events.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    logic [3:0] h;
    do c = 8'($urandom_range(0, 255)); while (nibble_of(c, h) || c == ChSpace);
    return c;
  endfunction

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 99) < 80) return 8'($urandom_range(8'h21, 8'h7e));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_header(input logic [15:0] len);
    for (int i = 3; i >= 0; i--) frame_bytes.push_back(hex_char(len[4*i +: 4]));
  endfunction

  function automatic void build_ref(input int name_len, input bit allow_bad);
    logic [7:0] pl[$];
    int         n;
    for (int i = 0; i < OidDigits; i++) pl.push_back(hex_char(4'($urandom_range(0, 15))));
    pl.push_back(ChSpace);
    for (int i = 0; i < name_len; i++) pl.push_back(text_byte());
    if ($urandom_range(0, 1)) begin
      pl.push_back(ChNul);
      n = $urandom_range(0, 16);
      for (int i = 0; i < n; i++)
        pl.push_back($urandom_range(0, 9) == 0 ? ChNul : text_byte());
    end
    if ($urandom_range(0, 1)) pl.push_back(ChNewline);
    if (allow_bad && $urandom_range(0, 99) < 15) pl[$urandom_range(0, OidDigits)] = non_hex_byte();
    push_header(16'(pl.size() + HdrDigits));
    foreach (pl[i]) frame_bytes.push_back(pl[i]);
  endfunction

  function automatic void build_frame(input bit want_big);
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (want_big) begin
      build_ref($urandom_range(300, 700), 1'b0);
    end else if (kind < 60) begin
      build_ref($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 24), 1'b1);
    end else if (kind < 68) begin
      push_header(16'h0000);
    end else if (kind < 73) begin
      push_header(16'(HdrDigits));
    end else if (kind < 78) begin
      push_header(16'($urandom_range(1, HdrDigits - 1)));
    end else if (kind < 86) begin
      n = $urandom_range(1, OidDigits);
      push_header(16'(n + HdrDigits));
      for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 94) begin
      n = $urandom_range(0, HdrDigits - 1);
      for (int i = 0; i < n; i++) frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
      frame_bytes.push_back(non_hex_byte());
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) frame_bytes.push_back(non_hex_byte());
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random back-pressure and field-by-field compare
  initial begin : event_sink
    int      stall;
    int      r;
    result_t want;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual tuser %0h tdata %0h tlast %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_res", want.event_res, m_axis_tuser);
          check_field("value", want.value, m_axis_tdata[7:0]);
          check_field("position", want.position, m_axis_tdata[23:8]);
          check_field("error_code", want.error_code, m_axis_tdata[26:24]);
          check_field("last", want.last, m_axis_tlast);
          check_field("tdata pad", 0, m_axis_tdata[31:27]);
        end
      end
      if ($urandom_range(0, 299) == 0) snk_steady = !snk_steady;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (snk_steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          stall = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        end
      end
    end
  end

  initial begin : byte_source
    int frames;
    bit big_done;
    frames = 0;
    big_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].typed,
                make_event(dir_tab[i].ev, 8'h00, 16'h0, dir_tab[i].err, 1'b1));

    while (bytes_sent < DirRows + RandItems) begin
      src_steady = ($urandom_range(0, 99) < 15);
      build_frame(!big_done && bytes_sent > 400);
      if (bytes_sent > 400) big_done = 1'b1;
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
      frame_bytes.delete();
      frames++;
      // let the output side run dry now and then
      if (frames % 4 == 0) drain_events();
    end

    drain_events();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/pktref_pkg.sv
hw/rtl/pkt_line_ref_advert_parser.sv
verif/tb_pkt_line_ref_advert_parser.sv
